// ----- rtl/ldau_pkg.sv -----
package ldau_pkg;

    // Field widths of the stream words and configuration registers.
    localparam int LOG_W    = 24;
    localparam int CMD_W    = 3;
    localparam int CUTOFF_W = 23;
    localparam int EPS_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 23;

    localparam int LOG_MAX = 8388607;
    localparam int LOG_MIN = -8388608;

    // Defaults for the top-level parameters.
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF     = 16;

    // Register reset values.
    localparam logic [CUTOFF_W-1:0] CUTOFF_RST = CUTOFF_W'(1048576);
    localparam logic [EPS_W-1:0]    EPS_RST    = EPS_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_CMP = 3'd4
    } ldau_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF  = 1'b0,
        CFG_EPSILON = 1'b1
    } ldau_cfg_t;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // The functions below only build the correction tables while the design
    // is elaborated. They use 30-bit fraction integer series for exp and ln.

    // Unsigned long division by shift and compare-subtract, one quotient bit
    // per step.
    function automatic logic [63:0] ldau_udiv(input logic [63:0] num,
                                              input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = 64'd0;
        rem = 65'd0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] ldau_exp_frac(input logic [63:0] f);
        logic [63:0] sum;
        logic [63:0] term;
        logic        done;
        sum  = Q30_ONE;
        term = Q30_ONE;
        done = 1'b0;
        for (int k = 1; k < 48; k++)
        begin
            if (!done)
            begin
                term = ldau_udiv((term * f) >> 30, 64'(k));
                if (term == 64'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] ldau_exp_neg(input logic [63:0] x);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] e1;
        n  = x >> 30;
        r  = ldau_udiv(64'd1 << 60, ldau_exp_frac(x & (Q30_ONE - 64'd1)));
        e1 = ldau_udiv(64'd1 << 60, ldau_exp_frac(Q30_ONE));
        for (int i = 0; i < 64; i++)
        begin
            if (64'(i) < n)
            begin
                r = (r * e1) >> 30;
            end
        end
        return r;
    endfunction

    function automatic longint ldau_ln_unit(input logic [63:0] y);
        logic [63:0] z;
        logic [63:0] zz;
        logic [63:0] p;
        logic [63:0] s;
        z  = ldau_udiv((y - Q30_ONE) << 30, y + Q30_ONE);
        zz = (z * z) >> 30;
        p  = z;
        s  = 64'd0;
        for (int j = 0; j < 64; j++)
        begin
            if (p != 64'd0)
            begin
                s = s + ldau_udiv(p, 64'(2 * j + 1));
                p = (p * zz) >> 30;
            end
        end
        return longint'(s << 1);
    endfunction

    function automatic longint ldau_ln_q30(input logic [63:0] y_in);
        logic [63:0] y;
        longint      k;
        y = (y_in == 64'd0) ? 64'd1 : y_in;
        k = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (y < Q30_ONE)
            begin
                y = y << 1;
                k = k + 1;
            end
        end
        return ldau_ln_unit(y) - k * ldau_ln_unit(Q30_ONE << 1);
    endfunction

    // Round half away from zero down to frac_bits fraction bits.
    function automatic longint ldau_to_frac(input longint v, input int frac_bits);
        int     s;
        longint half;
        s    = 30 - frac_bits;
        half = longint'(1) << (s - 1);
        if (v >= 0)
        begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    // One sample of ln(1+e^-x) or ln(1-e^-x) at x = idx*16/entries.
    // The first subtract sample sits one LSB in, where the function is finite.
    function automatic longint ldau_tbl_entry(input int idx, input int entries,
                                              input int frac_bits, input bit is_sub);
        logic [63:0] x;
        logic [63:0] xs;
        x  = ldau_udiv(64'(idx) << 34, 64'(entries));
        xs = (idx == 0) ? (64'd1 << (30 - frac_bits)) : x;
        if (is_sub)
        begin
            return ldau_to_frac(ldau_ln_q30(Q30_ONE - ldau_exp_neg(xs)), frac_bits);
        end
        return ldau_to_frac(ldau_ln_q30(Q30_ONE + ldau_exp_neg(x)), frac_bits);
    endfunction

    // Clamp a 25-bit signed sum to the 24-bit log range.
    function automatic logic [LOG_W:0] ldau_sat24(input logic signed [LOG_W:0] v);
        if (v > $signed((LOG_W+1)'(LOG_MAX)))
        begin
            return {1'b1, LOG_W'(LOG_MAX)};
        end
        if (v < $signed((LOG_W+1)'(LOG_MIN)))
        begin
            return {1'b1, LOG_W'(LOG_MIN)};
        end
        return {1'b0, v[LOG_W-1:0]};
    endfunction

endpackage

// ----- rtl/log_domain_arithmetic_unit.sv -----
// Log-domain arithmetic unit.
// Operands arrive on the slave stream: s_tuser carries the command (add,
// subtract, multiply, divide, compare) and s_tdata carries two operands,
// each a signed Q7.16 natural logarithm plus an exact-zero flag. One result
// word leaves on the master stream per accepted word, in order.
// The cfg channel writes the add/subtract cutoff (index 0) and the subtract
// equality epsilon (index 1); cfg_ready is always high. The user must make
// writes while the unit is idle; the block itself does not enforce this.
// The datapath is a five-stage pipeline: operand decode, table address,
// table read, interpolation multiply, and final add with saturation into the
// output register, which drives m_tvalid. A new word can be accepted every
// cycle while the receiver takes results, so the sustained rate is one word
// per clock.
// Reset clears all valid bits and loads the register defaults; the tables
// are constants and need no setup, so words are taken right after reset.
// When the receiver stalls, the output register holds its word, and the
// stall reaches back combinationally through full stages; empty stages keep
// filling, so bubbles are squeezed out and no word is dropped or repeated.
module log_domain_arithmetic_unit
    import ldau_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // a_log[23:0], a_zero[24], b_log[48:25], b_zero[49], zero fill [55:50]
    input  logic [55:0]           s_tdata,
    // command[2:0]
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_log[23:0], result_zero[24], less[25], greater[26], equal[27],
    // error[28], overflow[29], zero fill [31:30]
    output logic [31:0]           m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Span of the tables is 16.0, so the log difference has this many bits.
    localparam int SPAN = FRAC_BITS + 4;
    localparam int IW   = $clog2(TABLE_ENTRIES + 1);
    localparam int PW   = LOG_W + IW;
    // Table samples lie between about -(FRAC_BITS+1)*ln2 and ln2.
    localparam int TW   = FRAC_BITS + 6;
    localparam int PRW  = TW + SPAN + 2;
    localparam int SW   = ((TW > LOG_W) ? TW : LOG_W) + 2;

    typedef struct packed {
        logic signed [LOG_W-1:0] base;
        logic                    use_corr;
        logic                    tsub;
        logic                    rz;
        logic                    lt;
        logic                    gt;
        logic                    eq;
        logic                    err;
        logic                    ovf;
    } meta_t;

    // ------------------------------------------------------------------
    // Correction tables, built at elaboration.
    // ------------------------------------------------------------------
    logic signed [TW-1:0] add_rom [TABLE_ENTRIES+1];
    logic signed [TW-1:0] sub_rom [TABLE_ENTRIES+1];

    for (genvar g = 0; g <= TABLE_ENTRIES; g++)
    begin : g_rom
        localparam longint ADD_E = ldau_tbl_entry(g, TABLE_ENTRIES, FRAC_BITS, 1'b0);
        localparam longint SUB_E = ldau_tbl_entry(g, TABLE_ENTRIES, FRAC_BITS, 1'b1);
        assign add_rom[g] = TW'(ADD_E);
        assign sub_rom[g] = TW'(SUB_E);
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [EPS_W-1:0]    eps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_RST;
            eps_reg    <= EPS_RST;
        end
        else if (cfg_valid)
        begin
            case (ldau_cfg_t'(cfg_index))
                CFG_CUTOFF:  cutoff_reg <= cfg_data[CUTOFF_W-1:0];
                CFG_EPSILON: eps_reg    <= cfg_data[EPS_W-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline valid bits and stage advance. A stage loads when it is empty
    // or when the stage after it loads.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5     = !out_v_reg || m_tready;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
            if (adv5)
            begin
                out_v_reg <= v4_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: decode the command and resolve everything but the table
    // correction.
    // ------------------------------------------------------------------
    logic signed [LOG_W-1:0] a_log;
    logic signed [LOG_W-1:0] b_log;
    logic                    a_zero;
    logic                    b_zero;
    logic signed [LOG_W:0]   diff;
    logic signed [LOG_W:0]   sum;
    logic [LOG_W-1:0]        absd;
    logic signed [LOG_W-1:0] hi_log;
    logic                    a_gt;
    logic                    in_span;
    logic                    within_cut;
    logic                    below_eps;
    logic [LOG_W:0]          sat_sum;
    logic [LOG_W:0]          sat_diff;

    meta_t            meta1_next, meta1_reg;
    logic [LOG_W-1:0] absd1_reg;

    assign a_log  = s_tdata[23:0];
    assign a_zero = s_tdata[24];
    assign b_log  = s_tdata[48:25];
    assign b_zero = s_tdata[49];

    always_comb
    begin
        diff       = {a_log[LOG_W-1], a_log} - {b_log[LOG_W-1], b_log};
        sum        = {a_log[LOG_W-1], a_log} + {b_log[LOG_W-1], b_log};
        a_gt       = a_log > b_log;
        absd       = diff[LOG_W] ? LOG_W'(-diff) : diff[LOG_W-1:0];
        hi_log     = a_gt ? a_log : b_log;
        in_span    = (absd >> SPAN) == '0;
        within_cut = absd <= {1'b0, cutoff_reg};
        below_eps  = absd < {{(LOG_W-EPS_W){1'b0}}, eps_reg};
        sat_sum    = ldau_sat24(sum);
        sat_diff   = ldau_sat24(diff);

        meta1_next = '0;

        case (ldau_cmd_t'(s_tuser))
            CMD_ADD:
            begin
                meta1_next.tsub = 1'b0;
                if (a_zero && b_zero)
                begin
                    meta1_next.rz = 1'b1;
                end
                else if (a_zero)
                begin
                    meta1_next.base = b_log;
                end
                else if (b_zero)
                begin
                    meta1_next.base = a_log;
                end
                else
                begin
                    meta1_next.base     = hi_log;
                    meta1_next.use_corr = within_cut && in_span;
                end
            end
            CMD_SUB:
            begin
                meta1_next.tsub = 1'b1;
                if (a_zero && b_zero)
                begin
                    meta1_next.rz = 1'b1;
                end
                else if (b_zero)
                begin
                    meta1_next.base = a_log;
                end
                else if (a_zero)
                begin
                    meta1_next.err = 1'b1;
                end
                else if (below_eps)
                begin
                    meta1_next.rz = 1'b1;
                end
                else if (diff[LOG_W])
                begin
                    meta1_next.err = 1'b1;
                end
                else
                begin
                    // Past the cutoff the difference stays out of the table.
                    meta1_next.base     = a_log;
                    meta1_next.use_corr = within_cut && in_span;
                end
            end
            CMD_MUL:
            begin
                if (a_zero || b_zero)
                begin
                    meta1_next.rz = 1'b1;
                end
                else
                begin
                    meta1_next.base = sat_sum[LOG_W-1:0];
                    meta1_next.ovf  = sat_sum[LOG_W];
                end
            end
            CMD_DIV:
            begin
                if (b_zero)
                begin
                    meta1_next.err = 1'b1;
                end
                else if (a_zero)
                begin
                    meta1_next.rz = 1'b1;
                end
                else
                begin
                    meta1_next.base = sat_diff[LOG_W-1:0];
                    meta1_next.ovf  = sat_diff[LOG_W];
                end
            end
            CMD_CMP:
            begin
                // Zero ranks below every nonzero value.
                if (a_zero && b_zero)
                begin
                    meta1_next.eq = 1'b1;
                end
                else if (a_zero)
                begin
                    meta1_next.lt = 1'b1;
                end
                else if (b_zero)
                begin
                    meta1_next.gt = 1'b1;
                end
                else
                begin
                    meta1_next.lt = a_log < b_log;
                    meta1_next.gt = a_gt;
                    meta1_next.eq = a_log == b_log;
                end
            end
            default:
            begin
                meta1_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            meta1_reg <= meta1_next;
            absd1_reg <= absd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale the difference by the table size into a sample index
    // and an interpolation fraction.
    // ------------------------------------------------------------------
    logic [PW-1:0]   pos;
    logic [IW-1:0]   idx2_next;
    meta_t           meta2_reg;
    logic [IW-1:0]   idx2_reg;
    logic [SPAN-1:0] frac2_reg;

    always_comb
    begin
        pos       = PW'(absd1_reg) * PW'(TABLE_ENTRIES);
        idx2_next = IW'(pos >> SPAN);
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            meta2_reg <= meta1_reg;
            idx2_reg  <= idx2_next;
            frac2_reg <= pos[SPAN-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: read the two neighboring samples of the selected table.
    // ------------------------------------------------------------------
    logic [IW-1:0]        idx_up;
    meta_t                meta3_reg;
    logic signed [TW-1:0] lo3_reg;
    logic signed [TW-1:0] hi3_reg;
    logic [SPAN-1:0]      frac3_reg;

    assign idx_up = idx2_reg + IW'(1);

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            meta3_reg <= meta2_reg;
            frac3_reg <= frac2_reg;
            lo3_reg   <= meta2_reg.tsub ? sub_rom[idx2_reg] : add_rom[idx2_reg];
            hi3_reg   <= meta2_reg.tsub ? sub_rom[idx_up]   : add_rom[idx_up];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: slope times fraction.
    // ------------------------------------------------------------------
    logic signed [TW:0]    slope;
    meta_t                 meta4_reg;
    logic signed [TW-1:0]  lo4_reg;
    logic signed [PRW-1:0] prod4_reg;

    assign slope = {hi3_reg[TW-1], hi3_reg} - {lo3_reg[TW-1], lo3_reg};

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            meta4_reg <= meta3_reg;
            lo4_reg   <= lo3_reg;
            prod4_reg <= PRW'(slope * $signed({1'b0, frac3_reg}));
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: finish the interpolation (the quotient truncates toward
    // zero), add the correction and clamp into the output register.
    // ------------------------------------------------------------------
    logic signed [PRW-1:0] prod_bias;
    logic signed [TW:0]    step;
    logic signed [TW:0]    corr;
    logic signed [SW-1:0]  total;
    logic [LOG_W-1:0]      res_log;
    logic [29:0]           out_next;
    logic [29:0]           out_reg;

    always_comb
    begin
        prod_bias = prod4_reg + (prod4_reg[PRW-1] ? PRW'((64'd1 << SPAN) - 64'd1) : '0);
        step      = (TW+1)'(prod_bias >>> SPAN);
        corr      = {lo4_reg[TW-1], lo4_reg} + step;
        total     = SW'(meta4_reg.base) + SW'(corr);

        if (!meta4_reg.use_corr)
        begin
            res_log = meta4_reg.base;
        end
        else if (total > SW'(LOG_MAX))
        begin
            res_log = LOG_W'(LOG_MAX);
        end
        else if (total < SW'(LOG_MIN))
        begin
            res_log = LOG_W'(LOG_MIN);
        end
        else
        begin
            res_log = total[LOG_W-1:0];
        end

        out_next = {meta4_reg.ovf, meta4_reg.err, meta4_reg.eq, meta4_reg.gt,
                    meta4_reg.lt, meta4_reg.rz, res_log};
    end

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {2'b00, out_reg};

`ifndef SYNTHESIS
    // An error word never also claims a zero result, and carries a zero log.
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[28] |-> !m_tdata[24] && m_tdata[23:0] == '0)
        else $error("error word with zero flag or nonzero log");

    // At most one compare outcome is reported.
    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tdata[27:25]))
        else $error("more than one compare flag set");

    // Overflow only comes with a clamped log.
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[29] |->
            m_tdata[23:0] == LOG_W'(LOG_MAX) || m_tdata[23:0] == LOG_W'(LOG_MIN))
        else $error("overflow without a saturated result");

    // The input side only stalls when the first stage holds a word.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> v1_reg)
        else $error("input stalled with an empty first stage");

    // A word leaving the last internal stage lands in the output register.
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && adv5 |=> m_tvalid)
        else $error("word lost between stage four and output");
`endif

endmodule

// ----- tb/testbench.sv -----
// Testbench for the log-domain arithmetic unit.
//
// Operand words go in on the slave stream with random gaps, and result words
// come out on the master stream under random back-pressure. Every accepted
// operand word is run through a local predictor and the outcome is queued.
// Each result word is then checked field by field against the oldest entry.
// The predictor builds its own correction tables for ln(1+e^-x) and
// ln(1-e^-x) in 30-bit fraction integer arithmetic and rounds them to the
// block's fraction width, so table reads and interpolation are checked bit
// for bit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ldau_pkg::*;

    // Command codes that the block must answer with an all-zero word.
    localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam int N_ENTRIES  = TABLE_ENTRIES_DEF;
    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int SPAN_SHIFT = FRAC + 4;

    localparam bit [63:0] ONE_Q30 = 64'd1 << 30;

    // Watchdog limit; a run that goes longer counts as hung.
    localparam int CYCLE_LIMIT = 500000;
    // Settling wait after the last result is back, waited out before a register write.
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic signed [LOG_W-1:0] a_log;
        logic                    a_zero;
        logic signed [LOG_W-1:0] b_log;
        logic                    b_zero;
    } operand_pair_t;

    typedef struct {
        logic signed [LOG_W-1:0] log_val;
        logic                    is_zero;
        logic                    less;
        logic                    greater;
        logic                    equal;
        logic                    error;
        logic                    overflow;
    } ldau_result_t;

    // Clock, reset and every block input start at known values.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [55:0]           s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the two registers, loaded with the reset values.
    int unsigned model_cutoff  = CUTOFF_RST;
    int unsigned model_epsilon = EPS_RST;

    // Correction samples, built once at time zero.
    longint add_corr [0:N_ENTRIES];
    longint sub_corr [0:N_ENTRIES];

    ldau_result_t pending_results [$];

    // Idle profile: percent chance of a gap before a word or of a stall.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int stall_left   = 0;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int words_checked  = 0;
    int reg_writes     = 0;
    int words_sent [0:7];

    log_domain_arithmetic_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point exp and ln used to build the correction samples.
    // All values carry 30 fraction bits.
    // ------------------------------------------------------------------

    // e^f for f in [0,1] by Taylor series; stops once a term vanishes.
    function automatic bit [63:0] exp_series(input bit [63:0] f);
        bit [63:0] total;
        bit [63:0] term;
        int        k;
        total = ONE_Q30;
        term  = ONE_Q30;
        k     = 1;
        while (k < 48)
        begin
            term = ((term * f) >> 30) / 64'(k);
            if (term == 64'd0)
            begin
                k = 48;
            end
            else
            begin
                total = total + term;
                k++;
            end
        end
        return total;
    endfunction

    // e^-x: fractional part by reciprocal, then one factor of 1/e per unit.
    function automatic bit [63:0] exp_of_negative(input bit [63:0] x);
        bit [63:0] whole;
        bit [63:0] r;
        bit [63:0] inv_e;
        whole = x >> 30;
        r     = (64'd1 << 60) / exp_series(x & (ONE_Q30 - 64'd1));
        inv_e = (64'd1 << 60) / exp_series(ONE_Q30);
        for (int i = 0; i < 64; i++)
        begin
            if (64'(i) < whole)
            begin
                r = (r * inv_e) >> 30;
            end
        end
        return r;
    endfunction

    // ln(y) for y in [1,2] through the atanh series in z = (y-1)/(y+1).
    function automatic longint ln_of_unit(input bit [63:0] y);
        bit [63:0] z;
        bit [63:0] z_sq;
        bit [63:0] power;
        bit [63:0] acc;
        int        j;
        z     = ((y - ONE_Q30) << 30) / (y + ONE_Q30);
        z_sq  = (z * z) >> 30;
        power = z;
        acc   = 64'd0;
        j     = 0;
        while (j < 64 && power != 64'd0)
        begin
            acc   = acc + power / 64'(2 * j + 1);
            power = (power * z_sq) >> 30;
            j++;
        end
        return longint'(acc << 1);
    endfunction

    // ln(y) for y in (0,2]: scale up to [1,2] and take off ln 2 per step.
    function automatic longint ln_fixed(input bit [63:0] y);
        bit [63:0] v;
        longint    shifts;
        v      = (y == 64'd0) ? 64'd1 : y;
        shifts = 0;
        while (v < ONE_Q30)
        begin
            v = v << 1;
            shifts++;
        end
        return ln_of_unit(v) - shifts * ln_of_unit(ONE_Q30 << 1);
    endfunction

    // Drop to the block's fraction width, rounding half away from zero.
    function automatic longint round_frac(input longint v);
        int     s;
        longint half;
        s    = 30 - FRAC;
        half = longint'(1) << (s - 1);
        if (v >= 0)
        begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    // Sample i sits at x = 16*i/N_ENTRIES. The subtract curve is unbounded
    // at zero, so its first sample is taken one LSB to the right.
    initial
    begin
        bit [63:0] x;
        bit [63:0] xs;
        for (int i = 0; i <= N_ENTRIES; i++)
        begin
            x  = (64'(i) << 34) / 64'(N_ENTRIES);
            xs = (i == 0) ? (64'd1 << (30 - FRAC)) : x;
            add_corr[i] = round_frac(ln_fixed(ONE_Q30 + exp_of_negative(x)));
            sub_corr[i] = round_frac(ln_fixed(ONE_Q30 - exp_of_negative(xs)));
        end
    end

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------

    // Linear interpolation between samples; zero at or beyond d = 16.0.
    function automatic longint interp_correction(input bit subtract, input longint d);
        longint pos;
        longint idx;
        longint frac;
        longint lo;
        longint hi;
        if (d < 0 || d >= (longint'(1) << SPAN_SHIFT))
        begin
            return 0;
        end
        pos  = d * N_ENTRIES;
        idx  = pos >>> SPAN_SHIFT;
        if (idx >= N_ENTRIES)
        begin
            return 0;
        end
        frac = pos & ((longint'(1) << SPAN_SHIFT) - 1);
        lo   = subtract ? sub_corr[idx] : add_corr[idx];
        hi   = subtract ? sub_corr[idx + 1] : add_corr[idx + 1];
        return lo + ((hi - lo) * frac) / (longint'(1) << SPAN_SHIFT);
    endfunction

    function automatic longint clamp_log(input longint v, output bit hit);
        hit = 1'b0;
        if (v > LOG_MAX)
        begin
            hit = 1'b1;
            return LOG_MAX;
        end
        if (v < LOG_MIN)
        begin
            hit = 1'b1;
            return LOG_MIN;
        end
        return v;
    endfunction

    function automatic ldau_result_t predict_result(input operand_pair_t p);
        ldau_result_t res;
        longint       a;
        longint       b;
        longint       r;
        longint       d;
        longint       big;
        bit           sat_hit;
        bit           zero_res;
        bit           err;
        a        = p.a_log;
        b        = p.b_log;
        r        = 0;
        zero_res = 1'b0;
        err      = 1'b0;
        res      = '{default: 1'b0};
        case (p.cmd)
            CMD_ADD:
            begin
                if (p.a_zero && p.b_zero)
                begin
                    zero_res = 1'b1;
                end
                else if (p.a_zero)
                begin
                    r = b;
                end
                else if (p.b_zero)
                begin
                    r = a;
                end
                else
                begin
                    big = (a > b) ? a : b;
                    d   = (a > b) ? a - b : b - a;
                    r   = (d > longint'(model_cutoff)) ? big
                                                       : big + interp_correction(1'b0, d);
                    r   = clamp_log(r, sat_hit);
                end
            end
            CMD_SUB:
            begin
                if (p.a_zero && p.b_zero)
                begin
                    zero_res = 1'b1;
                end
                else if (p.b_zero)
                begin
                    r = a;
                end
                else if (p.a_zero)
                begin
                    err = 1'b1;
                end
                else
                begin
                    d = a - b;
                    if (((d < 0) ? -d : d) < longint'(model_epsilon))
                    begin
                        zero_res = 1'b1;
                    end
                    else if (d < 0)
                    begin
                        err = 1'b1;
                    end
                    else if (d > longint'(model_cutoff))
                    begin
                        r = a;
                    end
                    else
                    begin
                        r = clamp_log(a + interp_correction(1'b1, d), sat_hit);
                    end
                end
            end
            CMD_MUL:
            begin
                if (p.a_zero || p.b_zero)
                begin
                    zero_res = 1'b1;
                end
                else
                begin
                    r            = clamp_log(a + b, sat_hit);
                    res.overflow = sat_hit;
                end
            end
            CMD_DIV:
            begin
                if (p.b_zero)
                begin
                    err = 1'b1;
                end
                else if (p.a_zero)
                begin
                    zero_res = 1'b1;
                end
                else
                begin
                    r            = clamp_log(a - b, sat_hit);
                    res.overflow = sat_hit;
                end
            end
            CMD_CMP:
            begin
                if (p.a_zero && p.b_zero)
                begin
                    res.equal = 1'b1;
                end
                else if (p.a_zero)
                begin
                    res.less = 1'b1;
                end
                else if (p.b_zero)
                begin
                    res.greater = 1'b1;
                end
                else
                begin
                    res.less    = (a < b);
                    res.greater = (a > b);
                    res.equal   = (a == b);
                end
            end
            default:
            begin
            end
        endcase
        if (zero_res || err)
        begin
            r = 0;
        end
        if (err)
        begin
            zero_res = 1'b0;
        end
        res.log_val = r[LOG_W-1:0];
        res.is_zero = zero_res;
        res.error   = err;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(9) < 8)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    // Sends one operand word and queues its expected result once the word
    // is taken. The valid stays high afterwards so that back-to-back words
    // need no bubble; wait_idle drops it.
    task automatic send_pair(input operand_pair_t p);
        int gap;
        gap = 0;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            gap = idle_length();
        end
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = p.cmd;
        s_tdata  = {6'b0, p.b_zero, p.b_log, p.a_zero, p.a_log};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(predict_result(p));
        words_sent[p.cmd]++;
    endtask

    task automatic send_item(input logic [CMD_W-1:0] cmd, input longint a, input logic a_zero,
                             input longint b, input logic b_zero);
        operand_pair_t p;
        p.cmd    = cmd;
        p.a_log  = LOG_W'(a);
        p.a_zero = a_zero;
        p.b_log  = LOG_W'(b);
        p.b_zero = b_zero;
        send_pair(p);
    endtask

    // Stops sending, lets every outstanding result come back, then lets the
    // pipeline settle so that the block is idle.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input ldau_cfg_t idx, input int unsigned value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == CFG_CUTOFF)
        begin
            model_cutoff = value & ((1 << CUTOFF_W) - 1);
        end
        else
        begin
            model_epsilon = value & ((1 << EPS_W) - 1);
        end
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [LOG_W-1:0] extreme_log();
        case ($urandom_range(5))
            0: return LOG_W'(LOG_MAX);
            1: return LOG_W'(LOG_MIN);
            2: return '0;
            3: return '1;
            4: return LOG_W'(1);
            default: return LOG_W'($urandom);
        endcase
    endfunction

    // Random operand word. Four pairs in ten lie close together so that add
    // and subtract land inside the correction table; the rest are full-range or
    // extreme values. A few words carry an unused command.
    function automatic operand_pair_t random_pair();
        operand_pair_t p;
        int unsigned   mode;
        int unsigned   sel;
        int            span;
        int            base;
        int            delta;
        if ($urandom_range(99) < 4)
        begin
            p.cmd = CMD_W'($urandom_range(CMD_SPARE7, CMD_SPARE5));
        end
        else
        begin
            p.cmd = CMD_W'($urandom_range(CMD_CMP, CMD_ADD));
        end
        p.a_zero = ($urandom_range(99) < 8);
        p.b_zero = ($urandom_range(99) < 8);
        mode = $urandom_range(9);
        if (mode < 4)
        begin
            p.a_log = LOG_W'($urandom);
            p.b_log = LOG_W'($urandom);
        end
        else if (mode < 8)
        begin
            sel  = $urandom_range(9);
            span = (sel < 5) ? (1 << 21) : ((sel < 8) ? (1 << 16) : 64);
            base  = int'($urandom_range(1 << 23)) - (1 << 22);
            delta = int'($urandom_range(span));
            if ($urandom_range(3) == 0)
            begin
                delta = -delta;
            end
            p.a_log = LOG_W'(base);
            p.b_log = LOG_W'(base - delta);
        end
        else
        begin
            p.a_log = extreme_log();
            p.b_log = extreme_log();
        end
        return p;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_pair(random_pair());
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls on m_tready, changed at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end
        else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct)
        begin
            m_tready   = 1'b0;
            stall_left = idle_length() - 1;
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input longint want, input longint seen);
        mismatch_count++;
        if (mismatch_count <= 100)
        begin
            $display("[%0t] word %0d %s: expected %0d, got %0d",
                     $time, words_checked, what, want, seen);
        end
    endtask

    // Result checker: every word taken on the master side is compared
    // against the oldest expectation.
    always @(posedge clk)
    begin
        ldau_result_t want;
        ldau_result_t seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.log_val  = m_tdata[23:0];
            seen.is_zero  = m_tdata[24];
            seen.less     = m_tdata[25];
            seen.greater  = m_tdata[26];
            seen.equal    = m_tdata[27];
            seen.error    = m_tdata[28];
            seen.overflow = m_tdata[29];
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result word, tdata", 0, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen.log_val !== want.log_val)
                begin
                    report_mismatch("result_log", want.log_val, seen.log_val);
                end
                if (seen.is_zero !== want.is_zero)
                begin
                    report_mismatch("result_zero", want.is_zero, seen.is_zero);
                end
                if (seen.less !== want.less)
                begin
                    report_mismatch("less", want.less, seen.less);
                end
                if (seen.greater !== want.greater)
                begin
                    report_mismatch("greater", want.greater, seen.greater);
                end
                if (seen.equal !== want.equal)
                begin
                    report_mismatch("equal", want.equal, seen.equal);
                end
                if (seen.error !== want.error)
                begin
                    report_mismatch("error", want.error, seen.error);
                end
                if (seen.overflow !== want.overflow)
                begin
                    report_mismatch("overflow", want.overflow, seen.overflow);
                end
            end
            words_checked++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hand-picked words under the reset register values: zero operands,
    // saturation, the end of the table, negative differences, division by
    // zero, every compare outcome and the unused commands.
    task automatic test_directed_cases();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_item(CMD_ADD, 100, 1'b1, -100, 1'b1);
        send_item(CMD_ADD, 0, 1'b1, 12345, 1'b0);
        send_item(CMD_ADD, 65536, 1'b0, 65536, 1'b0);
        send_item(CMD_ADD, LOG_MAX, 1'b0, LOG_MAX, 1'b0);
        // Difference of exactly 16.0: just past the last interpolation step.
        send_item(CMD_ADD, 300000, 1'b0, 300000 - (1 << 20), 1'b0);
        send_item(CMD_ADD, LOG_MIN, 1'b0, LOG_MAX, 1'b0);
        send_item(CMD_SUB, 7, 1'b1, 9, 1'b1);
        send_item(CMD_SUB, 5000, 1'b0, 0, 1'b1);
        send_item(CMD_SUB, 0, 1'b1, 5000, 1'b0);
        send_item(CMD_SUB, 123456, 1'b0, 123456, 1'b0);
        send_item(CMD_SUB, 100, 1'b0, 200, 1'b0);
        send_item(CMD_SUB, 200000, 1'b0, 100000, 1'b0);
        // Tiny difference near the bottom of the range drives the log below
        // the minimum, so the result saturates without an overflow flag.
        send_item(CMD_SUB, LOG_MIN + 2, 1'b0, LOG_MIN, 1'b0);
        send_item(CMD_SUB, LOG_MAX, 1'b0, LOG_MIN, 1'b0);
        send_item(CMD_MUL, LOG_MAX, 1'b0, LOG_MAX, 1'b0);
        send_item(CMD_MUL, LOG_MIN, 1'b0, -1, 1'b0);
        send_item(CMD_MUL, 0, 1'b1, LOG_MAX, 1'b0);
        send_item(CMD_DIV, 1000, 1'b0, 0, 1'b1);
        send_item(CMD_DIV, 0, 1'b1, 99, 1'b0);
        send_item(CMD_DIV, LOG_MAX, 1'b0, LOG_MIN, 1'b0);
        send_item(CMD_CMP, 3, 1'b1, 4, 1'b1);
        send_item(CMD_CMP, 0, 1'b1, LOG_MIN, 1'b0);
        send_item(CMD_CMP, -5, 1'b0, 5, 1'b0);
        send_item(CMD_CMP, 5, 1'b0, -5, 1'b0);
        send_item(CMD_CMP, LOG_MIN, 1'b0, LOG_MIN, 1'b0);
        send_item(CMD_SPARE5, LOG_MAX, 1'b0, 1, 1'b0);
        send_item(CMD_SPARE7, LOG_MIN, 1'b1, -1, 1'b1);
        wait_idle();
    endtask

    // Several register settings, the extremes among them. Each setting is
    // followed by words on both sides of the cutoff and of epsilon, and then
    // by random traffic.
    task automatic test_register_settings();
        int unsigned cutoffs [4];
        int unsigned epsilons [4];
        longint      c;
        longint      e;
        cutoffs[0]  = 0;
        epsilons[0] = 0;
        cutoffs[1]  = (1 << CUTOFF_W) - 1;
        epsilons[1] = (1 << EPS_W) - 1;
        cutoffs[2]  = $urandom_range(1 << 21);
        epsilons[2] = $urandom_range((1 << EPS_W) - 1);
        cutoffs[3]  = CUTOFF_RST;
        epsilons[3] = EPS_RST;
        for (int s = 0; s < 4; s++)
        begin
            wait_idle();
            write_register(CFG_CUTOFF, cutoffs[s]);
            write_register(CFG_EPSILON, epsilons[s]);
            c = model_cutoff;
            e = model_epsilon;
            tx_idle_pct  = 10;
            rx_stall_pct = 10;
            send_item(CMD_ADD, 0, 1'b0, -c, 1'b0);
            send_item(CMD_ADD, 0, 1'b0, -(c + 1), 1'b0);
            send_item(CMD_SUB, 0, 1'b0, -c, 1'b0);
            send_item(CMD_SUB, 0, 1'b0, -(c + 1), 1'b0);
            // With a zero epsilon, a - a takes the first subtract sample.
            send_item(CMD_SUB, -4242, 1'b0, -4242, 1'b0);
            send_item(CMD_SUB, 0, 1'b0, -e, 1'b0);
            send_item(CMD_SUB, 0, 1'b0, -(e - 1), 1'b0);
            send_random(100);
        end
        wait_idle();
    endtask

    // Long random run under changing idle profiles: none, light on both
    // sides, a slow receiver, a slow sender, and a steady sender with stalls.
    task automatic test_random_traffic();
        int tx_pcts [5];
        int rx_pcts [5];
        tx_pcts = '{0, 20, 5, 50, 0};
        rx_pcts = '{0, 20, 50, 5, 30};
        for (int k = 0; k < 5; k++)
        begin
            tx_idle_pct  = tx_pcts[k];
            rx_stall_pct = rx_pcts[k];
            send_random(100);
        end
    endtask

    // The sender holds off until every result is back, then resumes.
    task automatic test_drain_pause();
        tx_idle_pct  = 10;
        rx_stall_pct = 25;
        send_random(40);
        wait_idle();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_random(40);
    endtask

    initial
    begin
        for (int k = 0; k < 8; k++)
        begin
            words_sent[k] = 0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_register_settings();
        test_random_traffic();
        test_drain_pause();

        wait_idle();
        if (pending_results.size() != 0)
        begin
            report_mismatch("results never delivered", 0, pending_results.size());
        end
        $display("Checked %0d result words in %0d cycles after %0d register writes.",
                 words_checked, cycle_count, reg_writes);
        $display("Words per command: add %0d, sub %0d, mul %0d, div %0d, cmp %0d, unused %0d.",
                 words_sent[CMD_ADD], words_sent[CMD_SUB], words_sent[CMD_MUL],
                 words_sent[CMD_DIV], words_sent[CMD_CMP],
                 words_sent[5] + words_sent[6] + words_sent[7]);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- log_domain_arithmetic_unit.f -----
rtl/ldau_pkg.sv
rtl/log_domain_arithmetic_unit.sv
tb/testbench.sv
